// ----- sv/ppsch_pkg.sv -----
// Shared types, constants and the ranking function of the priority scheduler.
`timescale 1ns / 1ps
package ppsch_pkg;

  // Number of task cells in the chain.
  localparam int TASK_SLOTS = 16;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 32;
  localparam int BURST_W = 16;
  localparam int ERR_W   = 2;

  // Request kinds carried by in_req_type.
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Error codes reported on out_error_code.
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO  = 2'd2;

  // One stored task.
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  localparam entry_t EMPTY_ENT = '0;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_DEC
  } cell_op_t;

  // Command broadcast along the chain.
  typedef struct packed {
    cell_op_t op;
    entry_t   new_ent;
  } cell_ctl_t;

  // Sequencer states of the top level.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } st_t;

  // True when task a must run before the stored task b. Equal priorities go to
  // the earlier arrival, then the lower id; a newcomer goes behind its equals.
  function automatic logic ranks_before(input entry_t a, input entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = a.prio > b.prio;
    end else if (a.arrival != b.arrival) begin
      res = a.arrival < b.arrival;
    end else begin
      res = a.task_id < b.task_id;
    end
    return res;
  endfunction

endpackage

// ----- sv/ppsch_cell.sv -----
// One cell of the sorted task chain: holds one task and trades it with its neighbours.
`timescale 1ns / 1ps
module ppsch_cell import ppsch_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl_i,
  input  entry_t    left_i,
  input  logic      left_keeps_i,
  input  entry_t    right_i,
  output entry_t    ent_o,
  output logic      keeps_o
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign ent_o = entry_r;

  // The cell keeps its task on an insert unless the newcomer ranks before that task.
  assign keeps_o = entry_r.valid && !ranks_before(ctl_i.new_ent, entry_r);

  // Next contents: hold, take the newcomer, shift from the left on insert,
  // shift from the right on removal of the head, or count down.
  always_comb begin
    entry_nxt = entry_r;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (!keeps_o) begin
          entry_nxt = left_keeps_i ? ctl_i.new_ent : left_i;
        end
      end
      CELL_POP: begin
        entry_nxt = right_i;
      end
      CELL_DEC: begin
        entry_nxt.remaining = entry_r.remaining - BURST_W'(1);
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // Only the valid flag is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.task_id   <= entry_nxt.task_id;
    entry_r.prio      <= entry_nxt.prio;
    entry_r.arrival   <= entry_nxt.arrival;
    entry_r.remaining <= entry_nxt.remaining;
  end

endmodule

// ----- sv/preemptive_priority_scheduler.sv -----
// Top level of the preemptive priority scheduler: sequencer, clock and the cell chain.
//
//   channel  ports                          beat taken when
//   request  start, busy, in_*              start high and busy low
//   result   out_valid, out_*               out_valid high (one cycle, no stall)
//
// For each request the beat is registered first, and then
// the cell chain inserts, counts down or shifts out its head while
// the result is registered. out_valid rises in the cycle after that, and a
// new request may be taken in that same cycle. The chain is kept sorted, so
// the best task always sits in the first cell. Reset clears every cell's
// valid flag, the time counter and the previous-task record.
`timescale 1ns / 1ps
module preemptive_priority_scheduler import ppsch_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [ID_W-1:0]    in_task_id,
  input  logic [PRIO_W-1:0]  in_task_priority,
  input  logic [BURST_W-1:0] in_burst_length,
  output logic               out_valid,
  output logic               out_busy_res,
  output logic [ID_W-1:0]    out_running_id,
  output logic               out_segment_start,
  output logic               out_finished,
  output logic [TIME_W-1:0]  out_time_now,
  output logic [ERR_W-1:0]   out_error_code
);

  st_t                state_r, state_nxt;
  logic               req_type_r;
  logic [ID_W-1:0]    req_id_r;
  logic [PRIO_W-1:0]  req_prio_r;
  logic [BURST_W-1:0] req_burst_r;

  logic [TIME_W-1:0]  clock_r, clock_nxt;
  logic               prev_active_r, prev_active_nxt;
  logic [ID_W-1:0]    prev_task_r, prev_task_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_busy_r, out_busy_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic               out_seg_r, out_seg_nxt;
  logic               out_fin_r, out_fin_nxt;
  logic [TIME_W-1:0]  out_time_r, out_time_nxt;
  logic [ERR_W-1:0]   out_err_r, out_err_nxt;

  cell_ctl_t          ctl;
  entry_t             ents [TASK_SLOTS];
  logic               keeps [TASK_SLOTS];

  logic               accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Sequencer, chain command and result for the item in execution.
  always_comb begin
    state_nxt       = state_r;
    clock_nxt       = clock_r;
    prev_active_nxt = prev_active_r;
    prev_task_nxt   = prev_task_r;
    out_valid_nxt   = 1'b0;
    out_busy_nxt    = out_busy_r;
    out_id_nxt      = out_id_r;
    out_seg_nxt     = out_seg_r;
    out_fin_nxt     = out_fin_r;
    out_time_nxt    = out_time_r;
    out_err_nxt     = out_err_r;

    ctl.op                = CELL_HOLD;
    ctl.new_ent.valid     = 1'b1;
    ctl.new_ent.task_id   = req_id_r;
    ctl.new_ent.prio      = req_prio_r;
    ctl.new_ent.arrival   = clock_r;
    ctl.new_ent.remaining = req_burst_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_seg_nxt   = 1'b0;
        out_fin_nxt   = 1'b0;
        out_err_nxt   = ERR_NONE;
        if (req_type_r == REQ_ARRIVE) begin
          // Arrival: insert unless the burst is zero or the chain is full.
          out_time_nxt = clock_r;
          if (req_burst_r == '0) begin
            out_err_nxt = ERR_ZERO;
          end else if (ents[TASK_SLOTS-1].valid) begin
            out_err_nxt = ERR_FULL;
          end else begin
            ctl.op = CELL_INSERT;
          end
          if ((ctl.op == CELL_INSERT) && !keeps[0]) begin
            out_busy_nxt = 1'b1;
            out_id_nxt   = req_id_r;
          end else begin
            out_busy_nxt = ents[0].valid;
            out_id_nxt   = ents[0].valid ? ents[0].task_id : '0;
          end
        end else begin
          // Tick: the head runs for one unit and leaves the chain when done.
          clock_nxt    = clock_r + TIME_W'(1);
          out_time_nxt = clock_r + TIME_W'(1);
          if (!ents[0].valid) begin
            prev_active_nxt = 1'b0;
            out_busy_nxt    = 1'b0;
            out_id_nxt      = '0;
          end else begin
            out_busy_nxt  = 1'b1;
            out_id_nxt    = ents[0].task_id;
            out_seg_nxt   = !prev_active_r || (prev_task_r != ents[0].task_id);
            prev_task_nxt = ents[0].task_id;
            if (ents[0].remaining == BURST_W'(1)) begin
              ctl.op          = CELL_POP;
              out_fin_nxt     = 1'b1;
              prev_active_nxt = 1'b0;
            end else begin
              ctl.op          = CELL_DEC;
              prev_active_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      clock_r       <= '0;
      prev_active_r <= 1'b0;
      prev_task_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clock_r       <= clock_nxt;
      prev_active_r <= prev_active_nxt;
      prev_task_r   <= prev_task_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r  <= in_req_type;
      req_id_r    <= in_task_id;
      req_prio_r  <= in_task_priority;
      req_burst_r <= in_burst_length;
    end
    out_busy_r <= out_busy_nxt;
    out_id_r   <= out_id_nxt;
    out_seg_r  <= out_seg_nxt;
    out_fin_r  <= out_fin_nxt;
    out_time_r <= out_time_nxt;
    out_err_r  <= out_err_nxt;
  end

  // The sorted chain; only the head counts down.
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    cell_ctl_t cctl;
    entry_t    left_ent;
    entry_t    right_ent;
    logic      left_keeps;

    always_comb begin
      cctl = ctl;
      if ((ctl.op == CELL_DEC) && (i != 0)) begin
        cctl.op = CELL_HOLD;
      end
    end

    if (i == 0) begin : g_head
      assign left_ent   = EMPTY_ENT;
      assign left_keeps = 1'b1;
    end else begin : g_body
      assign left_ent   = ents[i-1];
      assign left_keeps = keeps[i-1];
    end

    if (i == TASK_SLOTS - 1) begin : g_tail
      assign right_ent = EMPTY_ENT;
    end else begin : g_mid
      assign right_ent = ents[i+1];
    end

    ppsch_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (cctl),
      .left_i       (left_ent),
      .left_keeps_i (left_keeps),
      .right_i      (right_ent),
      .ent_o        (ents[i]),
      .keeps_o      (keeps[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_busy_res      = out_busy_r;
  assign out_running_id    = out_id_r;
  assign out_segment_start = out_seg_r;
  assign out_finished      = out_fin_r;
  assign out_time_now      = out_time_r;
  assign out_error_code    = out_err_r;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the preemptive priority scheduler.
`timescale 1ns / 1ps
module testbench;
  import ppsch_pkg::*;

  // Cycles with no beat on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;

  // What the scheduler reports for one request.
  typedef struct packed {
    logic               busy;
    logic [ID_W-1:0]    run_id;
    logic               seg;
    logic               fin;
    logic [TIME_W-1:0]  stamp;
    logic [ERR_W-1:0]   err;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_req_type = REQ_ARRIVE;
  logic [ID_W-1:0]    in_task_id = '0;
  logic [PRIO_W-1:0]  in_task_priority = '0;
  logic [BURST_W-1:0] in_burst_length = '0;
  logic               out_valid;
  logic               out_busy_res;
  logic [ID_W-1:0]    out_running_id;
  logic               out_segment_start;
  logic               out_finished;
  logic [TIME_W-1:0]  out_time_now;
  logic [ERR_W-1:0]   out_error_code;

  // Our own view of the ready table and the scheduler's bookkeeping.
  entry_t            task_table [TASK_SLOTS];
  logic [TIME_W-1:0] now_count = '0;
  logic              last_active = 1'b0;
  logic [ID_W-1:0]   last_id = '0;

  outcome_t outcomes_due [$];
  int       error_count = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  logic     steady = 1'b0;

  preemptive_priority_scheduler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_task_id        (in_task_id),
    .in_task_priority  (in_task_priority),
    .in_burst_length   (in_burst_length),
    .out_valid         (out_valid),
    .out_busy_res      (out_busy_res),
    .out_running_id    (out_running_id),
    .out_segment_start (out_segment_start),
    .out_finished      (out_finished),
    .out_time_now      (out_time_now),
    .out_error_code    (out_error_code)
  );

  always #5 clk = ~clk;

  // Prints one line per mismatch and counts it.
  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Strict ordering: higher priority, then earlier arrival, then lower id.
  function automatic logic outranks(input entry_t a, input entry_t b);
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    if (a.arrival != b.arrival) begin
      return a.arrival < b.arrival;
    end
    return a.task_id < b.task_id;
  endfunction

  // Slot of the task that would run next, or -1 when nothing is ready.
  // Scanning upwards with a strict test leaves full ties to the lowest slot.
  function automatic int best_slot();
    int pick;
    pick = -1;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      if (task_table[s].valid) begin
        if (pick < 0) begin
          pick = s;
        end else if (outranks(task_table[s], task_table[pick])) begin
          pick = s;
        end
      end
    end
    return pick;
  endfunction

  function automatic int table_fill();
    int n;
    n = 0;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      n += int'(task_table[s].valid);
    end
    return n;
  endfunction

  // Applies one request to the table and returns what the block must report.
  function automatic outcome_t run_scheduler(input logic kind, input logic [ID_W-1:0] tid,
                                             input logic [PRIO_W-1:0] tprio,
                                             input logic [BURST_W-1:0] tburst);
    outcome_t res;
    int       free_slot;
    int       top;
    res = '0;
    if (kind == REQ_ARRIVE) begin
      // The lowest free slot takes the newcomer; a zero burst is refused first.
      free_slot = -1;
      for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
        if (!task_table[s].valid) begin
          free_slot = s;
        end
      end
      if (tburst == '0) begin
        res.err = ERR_ZERO;
      end else if (free_slot < 0) begin
        res.err = ERR_FULL;
      end else begin
        task_table[free_slot].valid     = 1'b1;
        task_table[free_slot].task_id   = tid;
        task_table[free_slot].prio      = tprio;
        task_table[free_slot].arrival   = now_count;
        task_table[free_slot].remaining = tburst;
      end
      top = best_slot();
      if (top >= 0) begin
        res.busy   = 1'b1;
        res.run_id = task_table[top].task_id;
      end
    end else begin
      // A tick serves the best task for one unit, or idles on an empty table.
      top = best_slot();
      if (top < 0) begin
        last_active = 1'b0;
      end else begin
        res.busy   = 1'b1;
        res.run_id = task_table[top].task_id;
        res.seg    = !last_active || (last_id != task_table[top].task_id);
        task_table[top].remaining = task_table[top].remaining - BURST_W'(1);
        last_id     = task_table[top].task_id;
        last_active = 1'b1;
        if (task_table[top].remaining == '0) begin
          task_table[top].valid = 1'b0;
          res.fin     = 1'b1;
          last_active = 1'b0;
        end
      end
      now_count = now_count + TIME_W'(1);
    end
    res.stamp = now_count;
    return res;
  endfunction

  // The sender works in bursts; between bursts it usually drops start for a while.
  task automatic pace();
    int gap;
    if (steady) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offers one request beat and waits until the block takes it.
  task automatic issue(input logic kind, input logic [ID_W-1:0] tid,
                       input logic [PRIO_W-1:0] tprio, input logic [BURST_W-1:0] tburst);
    outcome_t due;
    start            <= 1'b1;
    in_req_type      <= kind;
    in_task_id       <= tid;
    in_task_priority <= tprio;
    in_burst_length  <= tburst;
    do @(posedge clk); while (busy !== 1'b0);
    due = run_scheduler(kind, tid, tprio, tburst);
    outcomes_due = {outcomes_due, due};
    pace();
  endtask

  task automatic arrive(input logic [ID_W-1:0] tid, input logic [PRIO_W-1:0] tprio,
                        input logic [BURST_W-1:0] tburst);
    issue(REQ_ARRIVE, tid, tprio, tburst);
  endtask

  // The task fields of a tick carry noise, since the block ignores them.
  task automatic tick();
    issue(REQ_TICK, ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 255)),
          BURST_W'($urandom_range(0, 65535)));
  endtask

  task automatic drain();
    while (table_fill() > 0) begin
      tick();
    end
  endtask

  // Ticks on an empty table idle, and a zero burst is refused.
  task automatic test_empty_table();
    tick();
    tick();
    arrive(8'h12, 8'h34, 16'd0);
    tick();
  endtask

  // Largest and smallest ids and priorities.
  task automatic test_field_extremes();
    arrive(8'hFF, 8'hFF, 16'd1);
    arrive(8'h00, 8'h00, 16'd2);
    tick();
    tick();
    tick();
    tick();
  endtask

  // A higher priority arrival takes over, and ties fall to arrival then id.
  task automatic test_preemption();
    arrive(8'd3, 8'd10, 16'd3);
    tick();
    arrive(8'd9, 8'd20, 16'd2);
    tick();
    arrive(8'd4, 8'd20, 16'd1);
    tick();
    tick();
    tick();
    tick();
    arrive(8'd7, 8'd5, 16'd1);
    arrive(8'd2, 8'd5, 16'd1);
    arrive(8'd2, 8'd5, 16'd2);
    drain();
  endtask

  // Filling every slot, then one arrival too many and a zero burst on top.
  task automatic test_table_full();
    for (int n = 0; n < TASK_SLOTS; n++) begin
      arrive(ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 255)), 16'd1);
    end
    arrive(8'h55, 8'hAA, 16'd5);
    arrive(8'hAA, 8'h55, 16'd0);
    drain();
  endtask

  // Mostly well-formed arrivals and ticks, with the table kept part full.
  task automatic test_random_mix(input int count);
    int fill;
    int roll;
    int arrive_pct;
    int pick;
    logic [BURST_W-1:0] len;
    for (int n = 0; n < count; n++) begin
      fill = table_fill();
      roll = $urandom_range(0, 99);
      arrive_pct = (fill >= TASK_SLOTS - 2) ? 25 : ((fill < 3) ? 70 : 45);
      pick = $urandom_range(0, 19);
      len = BURST_W'((pick < 15) ? $urandom_range(1, 6) :
                     (pick < 19) ? $urandom_range(7, 40) : $urandom_range(41, 100));
      if (roll < 4) begin
        arrive(ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 255)), 16'd0);
      end else if (roll < 4 + arrive_pct) begin
        // Narrow id and priority ranges force ties and duplicate ids.
        arrive(ID_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255)),
               PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255)),
               len);
      end else begin
        tick();
      end
    end
    drain();
  endtask

  // A full-length burst that keeps running, with short urgent tasks cutting in.
  task automatic test_long_burst();
    int ticks_done;
    ticks_done = 0;
    steady = 1'b1;
    arrive(8'hA5, 8'h5A, 16'hFFFF);
    while (ticks_done < 160) begin
      if (ticks_done == 80) begin
        steady = 1'b0;
      end
      if (ticks_done % 40 == 20) begin
        arrive(ID_W'($urandom_range(0, 255)), 8'hFF, 16'd3);
      end
      tick();
      ticks_done++;
    end
    steady = 1'b0;
  endtask

  // Each result beat is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid) begin
      if (outcomes_due.size() == 0) begin
        flag_error("result beat with no request outstanding");
      end else begin
        want = outcomes_due.pop_front();
        if (out_busy_res !== want.busy)
          flag_error($sformatf("busy_res %0b, want %0b", out_busy_res, want.busy));
        if (out_running_id !== want.run_id)
          flag_error($sformatf("running_id %0d, want %0d", out_running_id, want.run_id));
        if (out_segment_start !== want.seg)
          flag_error($sformatf("segment_start %0b, want %0b", out_segment_start, want.seg));
        if (out_finished !== want.fin)
          flag_error($sformatf("finished %0b, want %0b", out_finished, want.fin));
        if (out_time_now !== want.stamp)
          flag_error($sformatf("time_now %0d, want %0d", out_time_now, want.stamp));
        if (out_error_code !== want.err)
          flag_error($sformatf("error_code %0d, want %0d", out_error_code, want.err));
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < TASK_SLOTS; s++) begin
      task_table[s] = EMPTY_ENT;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_field_extremes();
    test_preemption();
    test_table_full();
    test_random_mix(400);
    test_long_burst();
    start <= 1'b0;
    while (outcomes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
